// ----- rtl/dep_pkg.sv -----
// ----------------------------------------------------------------------------
// dep_pkg : shared types and constants of the double-ended priority queue
// Request and response transfer types, op and error codes, and the types
// that pass between the queue cells and the control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // op codes; code 3 is unused and ignored
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_POP_MIN = 2'd1;
   localparam logic [1:0] OP_POP_MAX = 2'd2;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] priority_req;
      logic [31:0]        payload;
   } req_type;

   typedef struct packed {
      logic [31:0] out_payload;
      logic        out_valid;
      logic [1:0]  error_code;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        data;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_mode_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      cell_mode_type mode;
      entry_type     new_entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/dep_cell.sv -----
// ----------------------------------------------------------------------------
// dep_cell : one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes the
// left neighbour's; on a minimum pop it takes the right neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_cell
   import dep_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occ,
   input  wire entry_type     left_entry,
   input  wire logic          left_ge,
   input  wire entry_type     right_entry,
   output entry_type          entry,
   output logic               ge
);

   entry_type entry_ff;
   entry_type entry_in;

   // empty slot counts as "not smaller", so the flag is monotonic along the chain
   assign ge = !occ || ($signed(entry_ff.key) >= $signed(ctrl.new_entry.key));

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.mode)
         CELL_HOLD:   entry_in = entry_ff;
         CELL_SHIFT:  entry_in = right_entry;
         CELL_INSERT: begin
            if (!ge) begin
               entry_in = entry_ff;
            end else if (left_ge) begin
               entry_in = left_entry;
            end else begin
               entry_in = ctrl.new_entry;
            end
         end
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/double_ended_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core : sorted double-ended priority queue
// A chain of CAPACITY cells kept in ascending priority order, slot 0 at the
// minimum end, with an output register and a skid stage on the result side.
// ----------------------------------------------------------------------------
// Results go to the output register, or to the skid stage while it is held.
// Throughput: one request per cycle unless the skid stage is full; each cell
//   updates in the same cycle the request is taken, from its own compare.
// Reset: synchronous, active high; the queue empties (count to zero) and the
//   result stages clear. Cell contents are not reset.
`default_nettype none

module double_ended_priority_queue_core
   import dep_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // ---------------------------------------------------------------------
   // Handshake. The request side only stalls when the skid stage is full,
   // so a new request is taken while a finished result waits.
   // ---------------------------------------------------------------------
   logic req_take;
   logic out_take;

   logic    out_valid_ff,  out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff,        out_in;
   rsp_type skid_ff,       skid_in;

   logic [CNT_W-1:0] count_ff, count_in;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   cell_ctrl_type ctrl;
   entry_type     cell_entry [CAPACITY];
   logic          cell_ge    [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_g;

      if (i == 0) begin : g_first
         assign left_e = ctrl.new_entry;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_g = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      dep_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occ         (CNT_W'(i) < count_ff),
         .left_entry  (left_e),
         .left_ge     (left_g),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   // ---------------------------------------------------------------------
   // Request decode: pick the chain action and form the result
   // ---------------------------------------------------------------------
   rsp_type          result;
   logic [IDX_W-1:0] top_idx;
   logic             full;
   logic             empty;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign top_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      ctrl.mode           = CELL_HOLD;
      ctrl.new_entry.key  = req_data.priority_req;
      ctrl.new_entry.data = req_data.payload;
      count_in            = count_ff;
      result.out_payload  = '0;
      result.out_valid    = 1'b0;
      result.error_code   = ERR_OK;

      if (req_take) begin
         unique case (req_data.op)
            OP_INSERT: begin
               if (full) begin
                  result.error_code = ERR_FULL;
               end else begin
                  ctrl.mode = CELL_INSERT;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_POP_MIN, OP_POP_MAX: begin
               if (empty) begin
                  result.error_code = ERR_EMPTY;
               end else begin
                  result.out_valid = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
                  if (req_data.op == OP_POP_MIN) begin
                     ctrl.mode          = CELL_SHIFT;
                     result.out_payload = cell_entry[0].data;
                  end else begin
                     // max end: the top slot just drops out of the count
                     result.out_payload = cell_entry[top_idx].data;
                  end
               end
            end
            default: ;   // unused code: no change, no error
         endcase
      end
      result.entry_count = 5'(count_in);
   end

   // ---------------------------------------------------------------------
   // Output register plus skid stage
   // ---------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;

      if (req_take) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end else if (out_take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transfer with the output register empty");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(count_ff))
      else $error("entry count moved without a request transfer");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.op == OP_INSERT && !full) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the queue");

   a_pop_empty_err: assert property (@(posedge clock) disable iff (reset)
      (req_take && empty && (req_data.op == OP_POP_MIN || req_data.op == OP_POP_MAX))
         |-> (result.error_code == ERR_EMPTY && !result.out_valid))
      else $error("pop on empty queue not flagged");

endmodule

`default_nettype wire
